// File: rtl/fird_pkg.sv
// ============================================================================
// fird_pkg
// shared types, codes and default sizes of the fir decimator
// ============================================================================
package fird_pkg;

    // default sizes, handed to the top level parameters
    localparam int MAX_TAPS_DEF    = 64;
    localparam int MAX_DECIM_DEF   = 16;
    localparam int SAMPLE_BITS_DEF = 16;

    // fixed field widths
    localparam int ACTION_W    = 2;
    localparam int COEF_IDX_W  = 6;
    localparam int DECIM_W     = 5;
    localparam int TAPS_W      = 7;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 7;

    // register reset values
    localparam logic [DECIM_W-1:0] DECIM_RST = 5'd2;
    localparam logic [TAPS_W-1:0]  TAPS_RST  = 7'd64;

    // request kinds carried on the input tuser
    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH  = 2'd0,
        ACT_COEF  = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DECIM = 1'b0,
        CFG_TAPS  = 1'b1
    } t_cfg_idx;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_SAT
    } t_state;

    // sequencer to mac datapath controls
    typedef struct packed {
        logic acc_clr;  // zero the accumulator
        logic issue;    // a tap read was issued this cycle
        logic tap_ok;   // issued tap lies inside the filled window
        logic rnd_en;   // capture the rounded sum
    } t_mac_ctl;

endpackage

// File: rtl/fir_decimator_top.sv
// ============================================================================
// fir_decimator_top
// real fir decimator, q1.15 samples and coefficients, one shared mac
//
// input stream: tuser carries the request kind (push sample, write
// coefficient, clear window and phase); tdata carries from the lowest bit
// sample_in, coef_index and coef_value. output stream: tdata carries the
// rounded sample_out, tuser the saturated flag.
// configuration: i_cfg_we with i_cfg_addr 0 writes decim_factor, 1 writes
// tap_count; write only while no request is in progress.
// a push at phase zero yields one output: the taps are read one per cycle
// from the coefficient and window memories into the single multiplier,
// then the sum is drained, rounded and saturated into the output register.
// every other request is handled without leaving the idle state. the input
// is taken again once the output is registered.
// reset: a sweep over MAX_TAPS addresses zeroes the coefficient memory, with
// s_axis_tready low meanwhile; configuration writes are taken during it.
// the window memory is never cleared, a fill count masks unwritten taps.
// stall: the output register holds a result until taken; new requests are
// accepted meanwhile, and the next output waits in the last state.
// ============================================================================
module fir_decimator_top #(
    parameter int MAX_TAPS    = fird_pkg::MAX_TAPS_DEF,
    parameter int MAX_DECIM   = fird_pkg::MAX_DECIM_DEF,
    parameter int SAMPLE_BITS = fird_pkg::SAMPLE_BITS_DEF,
    localparam int IN_W  = ((2 * SAMPLE_BITS + fird_pkg::COEF_IDX_W + 7) / 8) * 8,
    localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [IN_W-1:0]                 s_axis_tdata,   // sample_in, coef_index, coef_value
    input  logic [fird_pkg::ACTION_W-1:0]   s_axis_tuser,   // action
    // output sample stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [OUT_W-1:0]                m_axis_tdata,   // sample_out
    output logic                            m_axis_tuser,   // saturated
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [fird_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [fird_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int SB = SAMPLE_BITS;
    localparam int AW = $clog2(MAX_TAPS);
    localparam int CW = $clog2(MAX_TAPS + 1);
    localparam int PW = $clog2(MAX_DECIM);
    localparam int IW = fird_pkg::COEF_IDX_W;

    // input fields
    logic [SB-1:0]     in_sample;
    logic [IW-1:0]     in_idx;
    logic [SB-1:0]     in_coef;
    fird_pkg::t_action in_action;

    assign in_sample = s_axis_tdata[SB-1:0];
    assign in_idx    = s_axis_tdata[SB +: IW];
    assign in_coef   = s_axis_tdata[SB + IW +: SB];
    assign in_action = fird_pkg::t_action'(s_axis_tuser);

    // configuration registers
    logic [fird_pkg::DECIM_W-1:0] r_decim;
    logic [fird_pkg::TAPS_W-1:0]  r_taps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decim <= fird_pkg::DECIM_RST;
            r_taps  <= fird_pkg::TAPS_RST;
        end else if (i_cfg_we) begin
            unique case (fird_pkg::t_cfg_idx'(i_cfg_addr))
                fird_pkg::CFG_DECIM: r_decim <= i_cfg_wdata[fird_pkg::DECIM_W-1:0];
                fird_pkg::CFG_TAPS:  r_taps  <= i_cfg_wdata;
            endcase
        end
    end

    // effective decimation and tap count after clamping
    int decim_eff;
    int taps_eff;

    always_comb begin
        if (r_decim == '0) begin
            decim_eff = 1;
        end else if (int'(r_decim) > MAX_DECIM) begin
            decim_eff = MAX_DECIM;
        end else begin
            decim_eff = int'(r_decim);
        end
        if (r_taps == '0) begin
            taps_eff = 1;
        end else if (int'(r_taps) > MAX_TAPS) begin
            taps_eff = MAX_TAPS;
        end else begin
            taps_eff = int'(r_taps);
        end
    end

    // sequencer state
    fird_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_clr_addr, n_clr_addr;   // coefficient sweep after reset
    logic [AW-1:0]    r_k, n_k;                 // tap being issued
    logic [AW-1:0]    r_wptr, n_wptr;           // slot of the newest sample
    logic [CW-1:0]    r_fill, n_fill;           // samples held since clear
    logic [PW-1:0]    r_phase, n_phase;
    logic             r_out_valid, n_out_valid;
    logic [SB-1:0]    r_out_data;
    logic             r_out_sat;

    // memory ports
    logic          win_we;
    logic [AW-1:0] win_waddr;
    logic [AW-1:0] win_raddr;
    logic [SB-1:0] win_rdata;
    logic          coef_we;
    logic [AW-1:0] coef_waddr;
    logic [SB-1:0] coef_wdata;
    logic [SB-1:0] coef_rdata;

    // mac
    fird_pkg::t_mac_ctl mac_ctl;
    logic               mac_busy;
    logic [SB-1:0]      mac_sample;
    logic               mac_sat;

    logic          out_load;
    logic [PW:0]   phase_inc;
    logic [AW:0]   rd_diff;

    assign phase_inc = {1'b0, r_phase} + 1'b1;
    // window slot k steps back from the newest, circular
    assign rd_diff   = {1'b0, r_wptr} - {1'b0, r_k};

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_k         = r_k;
        n_wptr      = r_wptr;
        n_fill      = r_fill;
        n_phase     = r_phase;
        mac_ctl     = '0;
        win_we      = 1'b0;
        coef_we     = 1'b0;
        coef_waddr  = AW'(in_idx);
        coef_wdata  = in_coef;
        out_load    = 1'b0;
        s_axis_tready = 1'b0;

        if (rd_diff[AW]) begin
            win_raddr = AW'(rd_diff + (AW + 1)'(MAX_TAPS));
        end else begin
            win_raddr = rd_diff[AW-1:0];
        end

        unique case (r_state)
            fird_pkg::ST_CLEAR: begin
                coef_we    = 1'b1;
                coef_waddr = r_clr_addr;
                coef_wdata = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(MAX_TAPS - 1)) begin
                    n_state = fird_pkg::ST_IDLE;
                end
            end
            fird_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    unique case (in_action)
                        fird_pkg::ACT_PUSH: begin
                            n_wptr = (r_wptr == AW'(MAX_TAPS - 1)) ? '0 : r_wptr + 1'b1;
                            win_we = 1'b1;
                            if (r_fill != CW'(MAX_TAPS)) begin
                                n_fill = r_fill + 1'b1;
                            end
                            // a phase left above a lowered factor wraps here too
                            if (phase_inc >= (PW + 1)'(decim_eff)) begin
                                n_phase = '0;
                            end else begin
                                n_phase = phase_inc[PW-1:0];
                            end
                            if (r_phase == '0) begin
                                mac_ctl.acc_clr = 1'b1;
                                n_k     = '0;
                                n_state = fird_pkg::ST_MAC;
                            end
                        end
                        fird_pkg::ACT_COEF: begin
                            // indexes past the store are dropped
                            coef_we = (int'(in_idx) < MAX_TAPS);
                        end
                        fird_pkg::ACT_CLEAR: begin
                            n_fill  = '0;
                            n_phase = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            fird_pkg::ST_MAC: begin
                mac_ctl.issue  = 1'b1;
                mac_ctl.tap_ok = (CW'(r_k) < r_fill);
                n_k            = r_k + 1'b1;
                if (r_k == AW'(taps_eff - 1)) begin
                    n_state = fird_pkg::ST_DRAIN;
                end
            end
            fird_pkg::ST_DRAIN: begin
                if (!mac_busy) begin
                    mac_ctl.rnd_en = 1'b1;
                    n_state        = fird_pkg::ST_SAT;
                end
            end
            fird_pkg::ST_SAT: begin
                if (!r_out_valid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = fird_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fird_pkg::ST_CLEAR;
            end
        endcase

        n_out_valid = r_out_valid;
        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (out_load) begin
            n_out_valid = 1'b1;
        end
    end

    assign win_waddr = n_wptr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fird_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_k         <= '0;
            r_wptr      <= '0;
            r_fill      <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_k         <= n_k;
            r_wptr      <= n_wptr;
            r_fill      <= n_fill;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= mac_sample;
            r_out_sat  <= mac_sat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_out_data);
    assign m_axis_tuser  = r_out_sat;

    // sample window, circular
    fird_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_TAPS)
    ) u_win_ram (
        .i_clk   (i_clk),
        .i_we    (win_we),
        .i_waddr (win_waddr),
        .i_wdata (in_sample),
        .i_raddr (win_raddr),
        .o_rdata (win_rdata)
    );

    // coefficient store, tap k at address k
    fird_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (coef_wdata),
        .i_raddr (r_k),
        .o_rdata (coef_rdata)
    );

    fird_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_TAPS    (MAX_TAPS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_coef   (coef_rdata),
        .i_sample (win_rdata),
        .o_busy   (mac_busy),
        .o_sample (mac_sample),
        .o_sat    (mac_sat)
    );

endmodule

// File: rtl/fird_ram.sv
// ============================================================================
// fird_ram
// simple dual port ram, one write and one registered read port
// ============================================================================
module fird_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/fird_mac.sv
// ============================================================================
// fird_mac
// shared multiply-accumulate with rounding and saturation to the sample range
// ============================================================================
module fird_mac #(
    parameter int SAMPLE_BITS = fird_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_TAPS    = fird_pkg::MAX_TAPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fird_pkg::t_mac_ctl            i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_coef,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_busy,
    output logic [SAMPLE_BITS-1:0]        o_sample,
    output logic                          o_sat
);

    localparam int SB    = SAMPLE_BITS;
    localparam int AW    = $clog2(MAX_TAPS);
    // growth of the tap sum, wrapping at 64 bits at most
    localparam int ACC_W = (2 * SB + AW + 1 > 64) ? 64 : 2 * SB + AW + 1;
    localparam int RW    = ACC_W - (SB - 1);

    localparam logic signed [ACC_W-1:0] RND_HALF =
        {{(ACC_W - SB + 1){1'b0}}, 1'b1, {(SB - 2){1'b0}}};
    localparam logic signed [RW-1:0] MAXV = {{(RW - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
    localparam logic signed [RW-1:0] MINV = {{(RW - SB + 1){1'b1}}, {(SB - 1){1'b0}}};

    logic                      r_rd_v;
    logic                      r_rd_ok;
    logic                      r_mul_v;
    logic signed [2*SB-1:0]    r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [RW-1:0]      r_rnd;
    logic signed [ACC_W-1:0]   rnd_sum;
    logic                      sat_hi;
    logic                      sat_lo;

    // read data arrives in the cycle after the issue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v  <= 1'b0;
            r_mul_v <= 1'b0;
        end else begin
            r_rd_v  <= i_ctl.issue;
            r_mul_v <= r_rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ok <= i_ctl.tap_ok;
        if (r_rd_v) begin
            // taps outside the filled window weigh nothing
            if (r_rd_ok) begin
                r_prod <= i_coef * i_sample;
            end else begin
                r_prod <= '0;
            end
        end
        if (i_ctl.acc_clr) begin
            r_acc <= '0;
        end else if (r_mul_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_ctl.rnd_en) begin
            r_rnd <= RW'(rnd_sum >>> (SB - 1));
        end
    end

    // round half up
    assign rnd_sum = r_acc + RND_HALF;

    assign sat_hi = (r_rnd > MAXV);
    assign sat_lo = (r_rnd < MINV);

    always_comb begin
        priority if (sat_hi) begin
            o_sample = {1'b0, {(SB - 1){1'b1}}};
        end else if (sat_lo) begin
            o_sample = {1'b1, {(SB - 1){1'b0}}};
        end else begin
            o_sample = r_rnd[SB-1:0];
        end
    end

    assign o_sat  = sat_hi | sat_lo;
    assign o_busy = r_rd_v | r_mul_v;

endmodule

// File: rtl/fird_checker.sv
// ============================================================================
// fird_checker
// port level checks of the fir decimator, bound to the top level
// ============================================================================
module fird_checker #(
    parameter int SAMPLE_BITS = fird_pkg::SAMPLE_BITS_DEF,
    localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [fird_pkg::ACTION_W-1:0] s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [OUT_W-1:0]              m_axis_tdata,
    input logic                          m_axis_tuser
);

    localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    // reset starts the coefficient sweep with an empty output
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !s_axis_tready)
        else $error("fird: output or input open right after reset");

    // a stalled output holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("fird: output changed while stalled");

    // only a sample push can produce an output
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid &&
            (s_axis_tuser != fird_pkg::ACT_PUSH) |=> !m_axis_tvalid)
        else $error("fird: output after a request that is not a push");

    // a clipped output sits at one end of the sample range
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (m_axis_tdata[SAMPLE_BITS-1:0] == S_MAX) ||
            (m_axis_tdata[SAMPLE_BITS-1:0] == S_MIN))
        else $error("fird: saturated flag with an in-range sample");

endmodule

bind fir_decimator_top fird_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_fird_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: test/fir_decimator_top_test.sv
`timescale 1ns / 100ps
// ============================================================================
// fir_decimator_top_test
// self-checking bench for the fir decimator: a short table of hand-picked
// requests and register writes, then random requests under eight register
// settings and four idle mixes, with every output sample compared against
// the value in its table row or a behavioral filter kept inside the bench
// ============================================================================
module fir_decimator_top_test;

    import fird_pkg::*;

    // input tdata: sample_in [15:0], coef_index [21:16], coef_value [37:22]
    localparam int IN_W  = ((2 * SAMPLE_BITS_DEF + COEF_IDX_W + 7) / 8) * 8;
    localparam int OUT_W = ((SAMPLE_BITS_DEF + 7) / 8) * 8;

    // the spare request code, accepted and ignored by the block
    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

    // this covers the longest output latency with margin
    localparam int SETTLE_CYC      = 80;
    localparam int NPHASE          = 8;
    localparam int ITEMS_PER_PHASE = 130;

    // register settings of the random phases, raw values so that zero and
    // out-of-range codes are exercised as well
    localparam logic [CFG_DATA_W-1:0] PH_DECIM [NPHASE] =
        '{7'd1, 7'd16, 7'd0, 7'd31, 7'd3, 7'd2, 7'd16, 7'd5};
    localparam logic [CFG_DATA_W-1:0] PH_TAPS [NPHASE] =
        '{7'd64, 7'd1, 7'd0, 7'd127, 7'd17, 7'd64, 7'd64, 7'd33};

    // one row of stimulus: a request or a register write
    typedef struct packed {
        logic                  is_reg;   // register write instead of a request
        t_cfg_idx              reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [ACTION_W-1:0]   act;
        logic [15:0]           smp;
        logic [COEF_IDX_W-1:0] cidx;
        logic [15:0]           cval;
        logic                  typed;    // expected output given in the row
        logic [15:0]           exp_smp;
        logic                  exp_sat;
    } t_step;

    // one filter output
    typedef struct packed {
        logic [15:0] value;
        logic        sat;
    } t_fir_out;

    // ------------------------------------------------------------------------
    // dut signals, inputs at known values from time zero
    // ------------------------------------------------------------------------
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata  = '0;     // sample_in, coef_index, coef_value
    logic [ACTION_W-1:0]   s_axis_tuser  = '0;     // action
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;           // sample_out
    logic                  m_axis_tuser;           // saturated
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;

    // expected output riding along with a table request
    logic                  dir_typed     = 1'b0;
    logic [15:0]           dir_exp_smp   = '0;
    logic                  dir_exp_sat   = 1'b0;

    // idle mix of the running phase
    int                    tx_idle_pct   = 0;
    int                    rx_stall_pct  = 0;

    // behavioral filter state
    logic signed [15:0]    win_mem  [MAX_TAPS_DEF];
    logic signed [15:0]    coef_mem [MAX_TAPS_DEF];
    int                    phase_cnt;
    logic [DECIM_W-1:0]    decim_cfg;
    logic [TAPS_W-1:0]     taps_cfg;

    // outputs predicted but not yet seen, oldest first
    t_fir_out              pending_outs [$];

    int                    n_errors   = 0;
    int                    n_outs     = 0;
    int                    n_reqs     = 0;
    int                    n_pushes   = 0;
    int                    n_reg_wr   = 0;

    fir_decimator_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // 125 MHz clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #10_000_000;
        $display("%0t ns: timeout, requests or outputs stopped moving", $time);
        $display("fir_decimator_top: mismatch");
        $finish;
    end

    // output side: random stalls at the rate of the running phase
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // ------------------------------------------------------------------------
    // filter prediction and output check, both sampled at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : fir_predict
        longint   acc;
        longint   rnd;
        int       n_taps;
        int       n_decim;
        logic     emit;
        t_fir_out got;
        t_fir_out want;
        if (!i_rst_n) begin
            foreach (win_mem[k]) begin
                win_mem[k]  = '0;
                coef_mem[k] = '0;
            end
            phase_cnt = 0;
            decim_cfg = DECIM_RST;
            taps_cfg  = TAPS_RST;
        end else begin
            // compare the output taken at this edge with the oldest prediction
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata[15:0], m_axis_tuser};
                if (pending_outs.size() == 0) begin
                    n_errors++;
                    $display("%0t ns: output with none expected: expected none actual %h/%b",
                             $time, got.value, got.sat);
                end else begin
                    want = pending_outs.pop_front();
                    n_outs++;
                    if (got.value !== want.value) begin
                        n_errors++;
                        $display("%0t ns: sample_out expected %h actual %h",
                                 $time, want.value, got.value);
                    end
                    if (got.sat !== want.sat) begin
                        n_errors++;
                        $display("%0t ns: saturated expected %b actual %b",
                                 $time, want.sat, got.sat);
                    end
                end
            end

            // register writes, masked to the register widths
            if (i_cfg_we) begin
                n_reg_wr++;
                if (t_cfg_idx'(i_cfg_addr) == CFG_DECIM) begin
                    decim_cfg = i_cfg_wdata[DECIM_W-1:0];
                end else begin
                    taps_cfg = i_cfg_wdata[TAPS_W-1:0];
                end
            end

            // request accepted at this edge
            if (s_axis_tvalid && s_axis_tready) begin
                n_reqs++;
                case (s_axis_tuser)
                    ACT_PUSH: begin
                        n_pushes++;
                        // zero acts as one, anything past the maximum as the maximum
                        n_decim = (decim_cfg == 0) ? 1 :
                                  (decim_cfg > MAX_DECIM_DEF) ? MAX_DECIM_DEF : int'(decim_cfg);
                        for (int k = MAX_TAPS_DEF - 1; k > 0; k--) begin
                            win_mem[k] = win_mem[k-1];
                        end
                        win_mem[0] = s_axis_tdata[15:0];
                        // a phase left above a lowered factor gives nothing and wraps
                        emit = (phase_cnt == 0);
                        phase_cnt++;
                        if (phase_cnt >= n_decim) begin
                            phase_cnt = 0;
                        end
                        if (emit) begin
                            if (dir_typed) begin
                                want = '{dir_exp_smp, dir_exp_sat};
                            end else begin
                                n_taps = (taps_cfg == 0) ? 1 :
                                         (taps_cfg > MAX_TAPS_DEF) ? MAX_TAPS_DEF :
                                         int'(taps_cfg);
                                acc = 0;
                                for (int k = 0; k < n_taps; k++) begin
                                    acc += longint'(coef_mem[k]) * longint'(win_mem[k]);
                                end
                                // sum of q2.30 products, round half up back to q1.15
                                rnd = (acc + 64'sd16384) >>> 15;
                                if (rnd > 32767) begin
                                    want = '{16'h7fff, 1'b1};
                                end else if (rnd < -32768) begin
                                    want = '{16'h8000, 1'b1};
                                end else begin
                                    want = '{16'(rnd), 1'b0};
                                end
                            end
                            pending_outs.push_back(want);
                        end
                    end
                    ACT_COEF: begin
                        // every 6-bit index lies inside the store
                        coef_mem[s_axis_tdata[21:16]] = s_axis_tdata[37:22];
                    end
                    ACT_CLEAR: begin
                        // window and phase only, coefficients stay
                        foreach (win_mem[k]) begin
                            win_mem[k] = '0;
                        end
                        phase_cnt = 0;
                    end
                    default: begin
                        // spare code: no state change, no output
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // table row builders
    // ------------------------------------------------------------------------
    function automatic t_step req(logic [ACTION_W-1:0] act, logic [15:0] smp,
                                  logic [COEF_IDX_W-1:0] cidx, logic [15:0] cval);
        t_step r;
        r      = '0;
        r.act  = act;
        r.smp  = smp;
        r.cidx = cidx;
        r.cval = cval;
        return r;
    endfunction

    // push whose output is plain from the row before it
    function automatic t_step chk(logic [15:0] smp, logic [15:0] exp_smp, logic exp_sat);
        t_step r;
        r         = '0;
        r.act     = ACT_PUSH;
        r.smp     = smp;
        r.typed   = 1'b1;
        r.exp_smp = exp_smp;
        r.exp_sat = exp_sat;
        return r;
    endfunction

    function automatic t_step wr(t_cfg_idx ri, logic [CFG_DATA_W-1:0] v);
        t_step r;
        r         = '0;
        r.is_reg  = 1'b1;
        r.reg_idx = ri;
        r.reg_val = v;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // driver tasks
    // ------------------------------------------------------------------------

    // present one request and hold it until the block takes it
    task automatic send(input t_step r);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.act;
        s_axis_tdata  <= IN_W'({r.cval, r.cidx, r.smp});
        dir_typed     <= r.typed;
        dir_exp_smp   <= r.exp_smp;
        dir_exp_sat   <= r.exp_sat;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    // stop requesting, let every predicted output drain, then let the mac
    // finish anything that produces no output
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_outs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx ri, input logic [CFG_DATA_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= ri;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_step       dir_tab [$];
        t_step       r;
        int          pick;
        logic [15:0] small_v;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // starts at the reset settings: decimation 2, 64 taps, coefficients zero
        dir_tab = '{
            chk(16'h7fff, 16'h0000, 1'b0),                  // all coefficients zero
            req(ACT_PUSH,  16'h8000, 6'd0,  16'h0000),      // odd phase, no output
            req(ACT_COEF,  16'h0000, 6'd0,  16'h8000),      // h0 = -1.0
            req(ACT_CLEAR, 16'h0000, 6'd0,  16'h0000),
            chk(16'h8000, 16'h7fff, 1'b1),                  // -1 * -1 clips high
            req(ACT_PUSH,  16'h0000, 6'd0,  16'h0000),
            req(ACT_COEF,  16'hffff, 6'd63, 16'h7fff),      // last tap, largest value
            req(ACT_COEF,  16'h0000, 6'd1,  16'h8000),
            req(ACT_PUSH,  16'h7fff, 6'd0,  16'h0000),
            req(ACT_NONE,  16'h5a5a, 6'd21, 16'h1234),      // spare code, ignored
            wr(CFG_DECIM, 7'd16),
            req(ACT_PUSH,  16'h0001, 6'd0,  16'h0000),      // walk the phase up to 6
            req(ACT_PUSH,  16'hfffe, 6'd0,  16'h0000),
            req(ACT_PUSH,  16'h4000, 6'd0,  16'h0000),
            req(ACT_PUSH,  16'hc000, 6'd0,  16'h0000),
            req(ACT_PUSH,  16'h2aaa, 6'd0,  16'h0000),
            wr(CFG_DECIM, 7'd3),                            // phase now beyond factor
            req(ACT_PUSH,  16'h1111, 6'd0,  16'h0000),      // no output, phase wraps
            req(ACT_PUSH,  16'hd555, 6'd0,  16'h0000),      // phase zero again
            wr(CFG_TAPS, 7'd1),
            wr(CFG_DECIM, 7'd1),
            req(ACT_PUSH,  16'h0000, 6'd0,  16'h0000),      // phase left at one wraps
            chk(16'h8000, 16'h7fff, 1'b1),                  // single tap clips high
            wr(CFG_TAPS, 7'd0),                             // zero taps act as one
            req(ACT_PUSH,  16'h7fff, 6'd0,  16'h0000),
            wr(CFG_DECIM, 7'd0),                            // zero factor acts as one
            wr(CFG_TAPS, 7'd2),
            req(ACT_PUSH,  16'h7fff, 6'd0,  16'h0000),
            req(ACT_PUSH,  16'h7fff, 6'd0,  16'h0000),      // two taps clip low
            wr(CFG_TAPS, 7'd127),                           // past the maximum
            req(ACT_PUSH,  16'h1234, 6'd0,  16'h0000),
            wr(CFG_DECIM, 7'd31),
            req(ACT_PUSH,  16'h8001, 6'd0,  16'h0000),
            req(ACT_CLEAR, 16'hffff, 6'd63, 16'hffff)
        };

        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_reg) begin
                wait_idle();
                write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
            end else begin
                send(dir_tab[i]);
            end
        end

        // random phases; the window and phase carry over between settings so a
        // lowered factor can meet a phase left above it
        for (int p = 0; p < NPHASE; p++) begin
            wait_idle();
            write_reg(CFG_DECIM, PH_DECIM[p]);
            write_reg(CFG_TAPS, PH_TAPS[p]);
            case (p % 4)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 45;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 45;
                end
                default: begin
                    tx_idle_pct  = 15;
                    rx_stall_pct = 15;
                end
            endcase
            repeat (ITEMS_PER_PHASE) begin
                r    = '0;
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    r.act = ACT_PUSH;
                end else if (pick < 88) begin
                    r.act = ACT_COEF;
                end else if (pick < 95) begin
                    r.act = ACT_CLEAR;
                end else begin
                    r.act = ACT_NONE;
                end
                // small values keep long sums inside range, full-scale ones clip
                small_v = 16'($urandom_range(0, 4095)) - 16'd2048;
                r.smp   = ($urandom_range(0, 3) == 0) ? small_v : 16'($urandom);
                small_v = 16'($urandom_range(0, 4095)) - 16'd2048;
                r.cidx  = COEF_IDX_W'($urandom);
                r.cval  = ($urandom_range(0, 1) == 0) ? small_v : 16'($urandom);
                send(r);
            end
        end

        wait_idle();
        $display("covered %0d requests (%0d sample pushes) and %0d register writes",
                 n_reqs, n_pushes, n_reg_wr);
        $display("checked %0d filter outputs over %0d settings and four idle mixes",
                 n_outs, NPHASE);
        if (n_errors == 0) begin
            $display("fir_decimator_top: match");
        end else begin
            $display("fir_decimator_top: mismatch");
        end
        $finish;
    end

endmodule
